// ===== hdl/ps2mq_pkg.sv =====
package ps2mq_pkg;

  localparam logic [7:0] SYNC_MASK   = 8'h08;
  localparam logic [7:0] BUTTON_MASK = 8'h07;

  typedef struct packed {
    logic signed [8:0] move_y;
    logic signed [7:0] move_x;
    logic [2:0]        buttons;
  } event_t;

  typedef struct packed {
    logic   complete;
    event_t evt;
  } packet_t;

  typedef struct packed {
    logic hit;
    logic dropped;
    logic pending;
  } queue_status_t;

endpackage

// ===== hdl/ps2mq_intf.sv =====
interface ps2mq_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface ps2mq_out_if;
  logic              valid;
  logic              ready;
  logic              event_valid;
  logic [2:0]        buttons;
  logic signed [7:0] move_x;
  logic signed [8:0] move_y;
  logic              pending;
  logic              dropped;

  modport source (output valid, output event_valid, output buttons, output move_x,
                  output move_y, output pending, output dropped, input ready);
  modport sink (input valid, input event_valid, input buttons, input move_x,
                input move_y, input pending, input dropped, output ready);
endinterface

// ===== hdl/ps2mq_assembler.sv =====
module ps2mq_assembler
  import ps2mq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output packet_t    pkt
);

  typedef enum logic [2:0] {
    POS_HEAD = 3'b001,
    POS_DX   = 3'b010,
    POS_DY   = 3'b100
  } pos_t;

  pos_t       pos_r, pos_nxt;
  logic [7:0] head_r, head_nxt;
  logic [7:0] dx_r, dx_nxt;
  logic       complete;

  always_comb begin
    pos_nxt  = pos_r;
    head_nxt = head_r;
    dx_nxt   = dx_r;
    complete = 1'b0;
    if (byte_take) begin
      unique case (pos_r)
        POS_HEAD: begin
          if ((rx_byte & SYNC_MASK) != 8'h00) begin
            head_nxt = rx_byte;
            pos_nxt  = POS_DX;
          end
        end
        POS_DX: begin
          dx_nxt  = rx_byte;
          pos_nxt = POS_DY;
        end
        POS_DY: begin
          complete = 1'b1;
          pos_nxt  = POS_HEAD;
        end
        default: pos_nxt = POS_HEAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HEAD;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    dx_r   <= dx_nxt;
  end

  always_comb begin
    pkt.complete    = complete;
    pkt.evt.buttons = head_r[2:0] & BUTTON_MASK[2:0];
    pkt.evt.move_x  = $signed(dx_r);
    pkt.evt.move_y  = -$signed({rx_byte[7], rx_byte});
  end

endmodule

// ===== hdl/ps2mq_queue.sv =====
module ps2mq_queue
  import ps2mq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  packet_t       pkt,
  input  logic          pop_req,
  output event_t        rd_evt,
  output queue_status_t status
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  event_t        mem [QUEUE_DEPTH];
  event_t        rdata_r;
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_adv, rd_adv;
  logic          empty, full, do_push, do_pop;

  assign wr_adv  = (wr_r == LAST) ? '0 : wr_r + 1'b1;
  assign rd_adv  = (rd_r == LAST) ? '0 : rd_r + 1'b1;
  assign empty   = (wr_r == rd_r);
  assign full    = (wr_adv == rd_r);
  assign do_push = step && pkt.complete && !full;
  assign do_pop  = step && pop_req && !empty;
  assign wr_nxt  = do_push ? wr_adv : wr_r;
  assign rd_nxt  = do_pop ? rd_adv : rd_r;

  always_comb begin
    status.hit     = do_pop;
    status.dropped = step && pkt.complete && full;
    status.pending = (wr_nxt != rd_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
    end else begin
      wr_r <= wr_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_r] <= pkt.evt;
    end
    if (step && pop_req) begin
      rdata_r <= mem[rd_r];
    end
  end

  assign rd_evt = rdata_r;

  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r <= LAST) else $error("write index out of range");
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_r <= LAST) else $error("read index out of range");
  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    do_push |=> (wr_r != rd_r)) else $error("queue empty after push");
  a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (rd_r == $past(rd_adv))) else $error("read index did not advance");
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.dropped |=> (wr_r == $past(wr_r))) else $error("write on dropped packet");

endmodule

// ===== hdl/ps2mq_out_stage.sv =====
module ps2mq_out_stage
  import ps2mq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          take,
  input  queue_status_t status,
  input  event_t        rd_evt,
  output logic          busy,
  output logic          event_valid,
  output logic [2:0]    buttons,
  output logic signed [7:0] move_x,
  output logic signed [8:0] move_y,
  output logic          pending,
  output logic          dropped
);

  logic          valid_r, valid_nxt;
  queue_status_t st_r;

  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      st_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (load) begin
        st_r <= status;
      end
    end
  end

  assign busy        = valid_r;
  assign event_valid = st_r.hit;
  assign buttons     = st_r.hit ? rd_evt.buttons : 3'd0;
  assign move_x      = st_r.hit ? rd_evt.move_x : 8'sd0;
  assign move_y      = st_r.hit ? rd_evt.move_y : 9'sd0;
  assign pending     = st_r.pending;
  assign dropped     = st_r.dropped;

endmodule

// ===== hdl/ps2mq_top_note.sv =====
module ps2mq_sync_check
  import ps2mq_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_event_valid,
  input logic out_dropped
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=> in_valid) else $error("input valid dropped while stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_event_valid && out_dropped)) else $error("pop and drop together");
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid) else $error("transfer gave no result");

endmodule

// ===== hdl/ps2_mouse_packet_event_fifo_unit.sv =====
// PS/2 mouse packet decoder with an event queue. Each input transfer is either a received
// mouse byte (cmd 0) or a pop request (cmd 1) and gives exactly one result transfer.
// Bytes are assembled into three-byte packets; an opening byte without bit 3 set is
// discarded. A complete packet is pushed as an event (buttons, move_x, negated move_y)
// into a circular queue of QUEUE_DEPTH slots holding at most QUEUE_DEPTH-1 events; when
// full the event is dropped and the result carries dropped = 1. One item is accepted per
// cycle unless a held result is stalled; its result is in the output register in the next
// cycle, fed by a combinational decode and queue update and by the registered read port
// of the event memory. A stalled output holds the input side until the result is taken.
module ps2_mouse_packet_event_fifo_unit
  import ps2mq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  ps2mq_in_if.sink    in_ch,
  ps2mq_out_if.source out_ch
);

  logic          in_fire, out_fire, busy, byte_take;
  packet_t       pkt;
  queue_status_t status;
  event_t        rd_evt;

  assign out_fire    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !busy || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign byte_take   = in_fire && !in_ch.cmd;

  ps2mq_assembler u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .rx_byte   (in_ch.rx_byte),
    .pkt       (pkt)
  );

  ps2mq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .pkt     (pkt),
    .pop_req (in_ch.cmd),
    .rd_evt  (rd_evt),
    .status  (status)
  );

  ps2mq_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (in_fire),
    .take        (out_fire),
    .status      (status),
    .rd_evt      (rd_evt),
    .busy        (busy),
    .event_valid (out_ch.event_valid),
    .buttons     (out_ch.buttons),
    .move_x      (out_ch.move_x),
    .move_y      (out_ch.move_y),
    .pending     (out_ch.pending),
    .dropped     (out_ch.dropped)
  );

  assign out_ch.valid = busy;

  ps2mq_sync_check u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_event_valid (out_ch.event_valid),
    .out_dropped     (out_ch.dropped)
  );

endmodule
